[sv/wpps_pkg.sv]
// Package for the wake power phase sequencer: phase and command codes,
// configuration register indexes, reset values and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package wpps_pkg;

  // Power phases
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_PREQUIET    = 3'd1,
    PH_SWITCHING   = 3'd2,
    PH_SETTLE      = 3'd3,
    PH_RENDER_WAIT = 3'd4,
    PH_FAIL_CLOSED = 3'd5
  } phase_t;

  // Command codes carried by req_type
  localparam logic [3:0] CMD_QUERY       = 4'd0;
  localparam logic [3:0] CMD_REQUEST     = 4'd1;
  localparam logic [3:0] CMD_EVALUATE    = 4'd2;
  localparam logic [3:0] CMD_BEGIN_SW    = 4'd3;
  localparam logic [3:0] CMD_BEGIN_SETTLE = 4'd4;
  localparam logic [3:0] CMD_BEGIN_RW    = 4'd5;
  localparam logic [3:0] CMD_COMPLETE_RW = 4'd6;
  localparam logic [3:0] CMD_FAIL_CLOSED = 4'd7;
  localparam logic [3:0] CMD_CANCEL      = 4'd8;
  localparam logic [3:0] CMD_ACQUIRE     = 4'd9;
  localparam logic [3:0] CMD_RELEASE     = 4'd10;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUIET   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_WARN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE    = 8'd3;

  localparam logic [31:0] RST_MIN_QUIET   = 32'd1000;
  localparam logic [31:0] RST_WAIT_WARN   = 32'd5000;
  localparam logic [31:0] RST_SETTLE_TIME = 32'd500;
  localparam logic [31:0] RST_FAILSAFE    = 32'd2000;

  typedef struct packed {
    logic [31:0] min_quiet_time;
    logic [31:0] wait_warning_time;
    logic [31:0] settle_time;
    logic [31:0] prequiet_failsafe;
  } cfg_t;

  // Sequencer state other than the activity count
  typedef struct packed {
    phase_t      phase;
    logic [31:0] phase_start;
    logic [31:0] quiet_start;
    logic [31:0] settle_deadline;
    logic        waiting_drain;
  } seq_state_t;

  // Result fields other than the activity count
  typedef struct packed {
    phase_t      phase_now;
    logic        ok;
    logic [31:0] prequiet_age;
    logic        drain_overdue;
    logic        ready_res;
    logic        background_paused;
    logic        ui_paused;
    logic        settle_ready;
  } seq_result_t;

endpackage

[sv/wake_power_phase_sequencer.sv]
// Top level of the wake power phase sequencer: input register, state and
// configuration registers, result register. Depends on wpps_pkg, wpps_step.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, req_type, now_ms     | input
//   out     | out_valid/out_ready, nine result fields | output
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data| input
//
// An item is registered in the input register and then evaluated into the
// result register; one item per cycle while out_ready does not stall it.
// A stalled result holds both stages; the input register still takes an
// item while the result register is full, if it is empty itself. cfg_ready is always high.
// Synchronous active-low reset restores phase idle, zero count and the
// default register values.
`timescale 1ns / 1ps

module wake_power_phase_sequencer
  import wpps_pkg::*;
#(
  parameter int unsigned MAX_ACTIVITIES = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_req_type,
  input  logic [31:0]          in_now_ms,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_phase_now,
  output logic                 out_ok,
  output logic [31:0]          out_prequiet_age,
  output logic [7:0]           out_active_count,
  output logic                 out_drain_overdue,
  output logic                 out_ready_res,
  output logic                 out_background_paused,
  output logic                 out_ui_paused,
  output logic                 out_settle_ready,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_ACTIVITIES + 1);
  localparam int unsigned EXT_W = (CNT_W > 8) ? CNT_W : 8;

  logic             s1_valid_r;
  logic [3:0]       s1_cmd_r;
  logic [31:0]      s1_now_r;
  logic             out_valid_r;
  seq_result_t      res_r;
  logic [7:0]       res_cnt_r;

  seq_state_t       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cfg_t             cfg_r;
  seq_result_t      res_nxt;
  logic [EXT_W-1:0] cnt_ext;
  logic             advance;

  // Pipeline flow control
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r <= in_req_type;
      s1_now_r <= in_now_ms;
    end
  end

  // Command evaluation
  wpps_step #(
    .MAX_ACTIVITIES(MAX_ACTIVITIES)
  ) u_step (
    .cmd     (s1_cmd_r),
    .now_ms  (s1_now_r),
    .cfg     (cfg_r),
    .st      (st_r),
    .cnt     (cnt_r),
    .st_nxt  (st_nxt),
    .cnt_nxt (cnt_nxt),
    .res     (res_nxt)
  );

  assign cnt_ext = EXT_W'(cnt_nxt);

  // Sequencer state, updated when an item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase           <= PH_IDLE;
      st_r.phase_start     <= '0;
      st_r.quiet_start     <= '0;
      st_r.settle_deadline <= '0;
      st_r.waiting_drain   <= 1'b0;
      cnt_r                <= '0;
    end else if (s1_valid_r && advance) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      res_r     <= res_nxt;
      res_cnt_r <= cnt_ext[7:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_quiet_time    <= RST_MIN_QUIET;
      cfg_r.wait_warning_time <= RST_WAIT_WARN;
      cfg_r.settle_time       <= RST_SETTLE_TIME;
      cfg_r.prequiet_failsafe <= RST_FAILSAFE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_QUIET:   cfg_r.min_quiet_time    <= cfg_data;
        CFG_WAIT_WARN:   cfg_r.wait_warning_time <= cfg_data;
        CFG_SETTLE_TIME: cfg_r.settle_time       <= cfg_data;
        CFG_FAILSAFE:    cfg_r.prequiet_failsafe <= cfg_data;
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // Output ports
  assign out_valid             = out_valid_r;
  assign out_phase_now         = res_r.phase_now;
  assign out_ok                = res_r.ok;
  assign out_prequiet_age      = res_r.prequiet_age;
  assign out_active_count      = res_cnt_r;
  assign out_drain_overdue     = res_r.drain_overdue;
  assign out_ready_res         = res_r.ready_res;
  assign out_background_paused = res_r.background_paused;
  assign out_ui_paused         = res_r.ui_paused;
  assign out_settle_ready      = res_r.settle_ready;

endmodule

[sv/wpps_step.sv]
// Command evaluation for the wake power phase sequencer: from the held state
// and one command, the next state and the result item. Purely combinational.
// Depends on wpps_pkg.
`timescale 1ns / 1ps

module wpps_step
  import wpps_pkg::*;
#(
  parameter int unsigned MAX_ACTIVITIES = 255
) (
  input  logic [3:0]                              cmd,
  input  logic [31:0]                             now_ms,
  input  cfg_t                                    cfg,
  input  seq_state_t                              st,
  input  logic [$clog2(MAX_ACTIVITIES+1)-1:0]     cnt,
  output seq_state_t                              st_nxt,
  output logic [$clog2(MAX_ACTIVITIES+1)-1:0]     cnt_nxt,
  output seq_result_t                             res
);

  localparam int unsigned CNT_W = $clog2(MAX_ACTIVITIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ACTIVITIES);

  logic [31:0] since_phase;
  logic        failsafe_hit;
  phase_t      ph_chk;
  logic [31:0] quiet_eff;
  logic [31:0] quiet_span;
  logic [31:0] since_deadline;
  logic [31:0] since_new_deadline;

  // Prequiet failsafe, applied by query, request, evaluate and acquire
  assign since_phase  = now_ms - st.phase_start;
  assign failsafe_hit = (st.phase == PH_PREQUIET) && (since_phase >= cfg.prequiet_failsafe);
  assign ph_chk       = failsafe_hit ? PH_IDLE : st.phase;

  // Quiet interval restarts on the first drained evaluate
  assign quiet_eff  = st.waiting_drain ? now_ms : st.quiet_start;
  assign quiet_span = now_ms - quiet_eff;

  assign since_deadline = now_ms - st.settle_deadline;

  // Command decode and state update
  always_comb begin
    st_nxt            = st;
    cnt_nxt           = cnt;
    res.ok            = 1'b0;
    res.prequiet_age  = '0;
    res.drain_overdue = 1'b0;
    res.ready_res     = 1'b0;
    case (cmd)
      CMD_QUERY: begin
        st_nxt.phase = ph_chk;
      end
      CMD_REQUEST: begin
        st_nxt.phase = ph_chk;
        if (ph_chk == PH_PREQUIET) begin
          res.ok = 1'b1;
        end else if (ph_chk == PH_IDLE) begin
          st_nxt.phase           = PH_PREQUIET;
          st_nxt.phase_start     = now_ms;
          st_nxt.quiet_start     = now_ms;
          st_nxt.waiting_drain   = 1'b1;
          st_nxt.settle_deadline = '0;
          res.ok                 = 1'b1;
        end
      end
      CMD_EVALUATE: begin
        st_nxt.phase = ph_chk;
        if (ph_chk == PH_PREQUIET) begin
          res.prequiet_age = since_phase;
          if (cnt != '0) begin
            res.drain_overdue    = (since_phase >= cfg.wait_warning_time);
            st_nxt.waiting_drain = 1'b1;
            st_nxt.quiet_start   = now_ms;
          end else begin
            st_nxt.waiting_drain = 1'b0;
            st_nxt.quiet_start   = quiet_eff;
            res.ready_res        = (quiet_span >= cfg.min_quiet_time);
          end
        end
      end
      CMD_BEGIN_SW: begin
        if ((cnt == '0) && (st.phase == PH_PREQUIET)) begin
          st_nxt.phase         = PH_SWITCHING;
          st_nxt.waiting_drain = 1'b0;
          res.ok               = 1'b1;
        end
      end
      CMD_BEGIN_SETTLE: begin
        st_nxt.phase           = PH_SETTLE;
        st_nxt.phase_start     = now_ms;
        st_nxt.settle_deadline = now_ms + cfg.settle_time;
      end
      CMD_BEGIN_RW: begin
        if (st.phase == PH_RENDER_WAIT) begin
          res.ok = 1'b1;
        end else if ((st.phase == PH_SETTLE) && !since_deadline[31]) begin
          st_nxt.phase = PH_RENDER_WAIT;
          res.ok       = 1'b1;
        end
      end
      CMD_COMPLETE_RW: begin
        if (st.phase == PH_RENDER_WAIT) begin
          st_nxt.phase = PH_IDLE;
          res.ok       = 1'b1;
        end
      end
      CMD_FAIL_CLOSED: begin
        if (st.phase inside {PH_IDLE, PH_PREQUIET}) begin
          st_nxt.phase = PH_FAIL_CLOSED;
        end
      end
      CMD_CANCEL: begin
        st_nxt.phase           = PH_IDLE;
        st_nxt.phase_start     = '0;
        st_nxt.quiet_start     = '0;
        st_nxt.settle_deadline = '0;
        st_nxt.waiting_drain   = 1'b0;
      end
      CMD_ACQUIRE: begin
        st_nxt.phase = ph_chk;
        if ((ph_chk == PH_IDLE) && (cnt < CNT_MAX)) begin
          cnt_nxt = cnt + CNT_W'(1);
          res.ok  = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (cnt != '0) begin
          cnt_nxt = cnt - CNT_W'(1);
        end
      end
      default: begin
        // unknown code: state held, ok stays low
      end
    endcase

    // Phase-derived result flags, taken after the command
    since_new_deadline    = now_ms - st_nxt.settle_deadline;
    res.phase_now         = st_nxt.phase;
    res.background_paused = (st_nxt.phase != PH_IDLE);
    res.ui_paused         = (st_nxt.phase != PH_IDLE) && (st_nxt.phase != PH_RENDER_WAIT);
    res.settle_ready      = (st_nxt.phase == PH_SETTLE) && !since_new_deadline[31];
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for wake_power_phase_sequencer: directed command
// sequences, activity count saturation and random sessions over a sweep of
// register settings. Depends on wpps_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb_top;
  import wpps_pkg::*;

  localparam int unsigned ACT_LIMIT    = 255;
  localparam int unsigned RANDOM_ITEMS = 192;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [3:0]  CMD_UNUSED_LO = 4'd11;
  localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;

  // One result item as the sequencer reports it
  typedef struct packed {
    phase_t      phase_now;
    logic        ok;
    logic [31:0] prequiet_age;
    logic [7:0]  active_count;
    logic        drain_overdue;
    logic        ready_res;
    logic        background_paused;
    logic        ui_paused;
    logic        settle_ready;
  } guard_reply_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [3:0]  in_req_type = CMD_QUERY;
  logic [31:0] in_now_ms   = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [2:0]  out_phase_now;
  logic        out_ok;
  logic [31:0] out_prequiet_age;
  logic [7:0]  out_active_count;
  logic        out_drain_overdue;
  logic        out_ready_res;
  logic        out_background_paused;
  logic        out_ui_paused;
  logic        out_settle_ready;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_QUIET;
  logic [31:0] cfg_data    = '0;

  // Mirror of the guard state and its registers
  phase_t      g_phase       = PH_IDLE;
  logic [31:0] g_phase_start = '0;
  logic [31:0] g_quiet_start = '0;
  logic [31:0] g_settle_dl   = '0;
  logic [7:0]  g_count       = '0;
  logic        g_drain       = 1'b0;
  logic [31:0] c_min_quiet   = RST_MIN_QUIET;
  logic [31:0] c_wait_warn   = RST_WAIT_WARN;
  logic [31:0] c_settle_time = RST_SETTLE_TIME;
  logic [31:0] c_failsafe    = RST_FAILSAFE;

  guard_reply_t guard_replies[$];
  guard_reply_t oldest_reply;
  logic [31:0]  wall_ms       = '0;
  int unsigned  sent_items    = 0;
  bit           steady        = 1'b0;
  bit           mismatch_seen = 1'b0;

  wake_power_phase_sequencer #(
    .MAX_ACTIVITIES(ACT_LIMIT)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_phase_now        (out_phase_now),
    .out_ok               (out_ok),
    .out_prequiet_age     (out_prequiet_age),
    .out_active_count     (out_active_count),
    .out_drain_overdue    (out_drain_overdue),
    .out_ready_res        (out_ready_res),
    .out_background_paused(out_background_paused),
    .out_ui_paused        (out_ui_paused),
    .out_settle_ready     (out_settle_ready),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #(2_000_000);
    $display("Some tests failed");
    $finish;
  end

  // Prequiet times out to idle once the failsafe interval has passed
  function automatic void drop_stale_prequiet(input logic [31:0] now);
    if (g_phase == PH_PREQUIET && (now - g_phase_start) >= c_failsafe) g_phase = PH_IDLE;
  endfunction

  // Apply one command to the mirrored state and build its result
  function automatic guard_reply_t step_guard(input logic [3:0] cmd, input logic [31:0] now);
    guard_reply_t r;
    logic [31:0]  sdiff;
    r = '0;
    sdiff = now - g_settle_dl;
    case (cmd)
      CMD_QUERY: drop_stale_prequiet(now);
      CMD_REQUEST: begin
        drop_stale_prequiet(now);
        if (g_phase == PH_PREQUIET) begin
          r.ok = 1'b1;
        end else if (g_phase == PH_IDLE) begin
          g_phase_start = now;
          g_quiet_start = now;
          g_phase       = PH_PREQUIET;
          g_drain       = 1'b1;
          g_settle_dl   = '0;
          r.ok          = 1'b1;
        end
      end
      CMD_EVALUATE: begin
        drop_stale_prequiet(now);
        if (g_phase == PH_PREQUIET) begin
          r.prequiet_age = now - g_phase_start;
          if (g_count != 0) begin
            r.drain_overdue = (r.prequiet_age >= c_wait_warn);
            g_drain         = 1'b1;
            g_quiet_start   = now;
          end else begin
            // quiet interval restarts when the last activity drains
            if (g_drain) begin
              g_drain       = 1'b0;
              g_quiet_start = now;
            end
            r.ready_res = ((now - g_quiet_start) >= c_min_quiet);
          end
        end
      end
      CMD_BEGIN_SW: begin
        if (g_count == 0 && g_phase == PH_PREQUIET) begin
          g_phase = PH_SWITCHING;
          g_drain = 1'b0;
          r.ok    = 1'b1;
        end
      end
      CMD_BEGIN_SETTLE: begin
        g_phase_start = now;
        g_settle_dl   = now + c_settle_time;
        g_phase       = PH_SETTLE;
      end
      CMD_BEGIN_RW: begin
        if (g_phase == PH_RENDER_WAIT) begin
          r.ok = 1'b1;
        end else if (g_phase == PH_SETTLE && !sdiff[31]) begin
          g_phase = PH_RENDER_WAIT;
          r.ok    = 1'b1;
        end
      end
      CMD_COMPLETE_RW: begin
        if (g_phase == PH_RENDER_WAIT) begin
          g_phase = PH_IDLE;
          r.ok    = 1'b1;
        end
      end
      CMD_FAIL_CLOSED: begin
        if (g_phase == PH_IDLE || g_phase == PH_PREQUIET) g_phase = PH_FAIL_CLOSED;
      end
      CMD_CANCEL: begin
        g_settle_dl   = '0;
        g_phase_start = '0;
        g_quiet_start = '0;
        g_drain       = 1'b0;
        g_phase       = PH_IDLE;
      end
      CMD_ACQUIRE: begin
        drop_stale_prequiet(now);
        if (g_phase == PH_IDLE && g_count < ACT_LIMIT) begin
          g_count = g_count + 8'd1;
          r.ok    = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (g_count != 0) g_count = g_count - 8'd1;
      end
      default: ;
    endcase
    // deadline test uses the deadline as it stands after the command
    sdiff = now - g_settle_dl;
    r.phase_now         = g_phase;
    r.active_count      = g_count;
    r.background_paused = (g_phase != PH_IDLE);
    r.ui_paused         = (g_phase != PH_IDLE && g_phase != PH_RENDER_WAIT);
    r.settle_ready      = (g_phase == PH_SETTLE && !sdiff[31]);
    return r;
  endfunction

  // Result side: random back-pressure unless in a steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 17);
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (guard_replies.size() == 0) begin
        $error("result item with no prediction pending");
        mismatch_seen = 1'b1;
      end else begin
        oldest_reply = guard_replies.pop_front();
        check_field("phase_now", oldest_reply.phase_now, out_phase_now);
        check_field("ok", oldest_reply.ok, out_ok);
        check_field("prequiet_age", oldest_reply.prequiet_age, out_prequiet_age);
        check_field("active_count", oldest_reply.active_count, out_active_count);
        check_field("drain_overdue", oldest_reply.drain_overdue, out_drain_overdue);
        check_field("ready_res", oldest_reply.ready_res, out_ready_res);
        check_field("background_paused", oldest_reply.background_paused,
                    out_background_paused);
        check_field("ui_paused", oldest_reply.ui_paused, out_ui_paused);
        check_field("settle_ready", oldest_reply.settle_ready, out_settle_ready);
      end
    end
  end

  // Send one command item; predict its result when it is taken
  task automatic issue_cmd(input logic [3:0] cmd, input logic [31:0] now);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 17) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= cmd;
    in_now_ms   <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guard_replies.push_back(step_guard(cmd, now));
    sent_items++;
  endtask

  // Stop sending and let every pending result come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (guard_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_QUIET:   c_min_quiet   = data;
      CFG_WAIT_WARN:   c_wait_warn   = data;
      CFG_SETTLE_TIME: c_settle_time = data;
      CFG_FAILSAFE:    c_failsafe    = data;
      default: ;
    endcase
  endtask

  // Registers change only with no command item in flight
  task automatic program_regs(input logic [31:0] min_quiet, input logic [31:0] wait_warn,
                              input logic [31:0] settle, input logic [31:0] failsafe);
    wait_drained();
    write_reg(CFG_MIN_QUIET, min_quiet);
    write_reg(CFG_WAIT_WARN, wait_warn);
    write_reg(CFG_SETTLE_TIME, settle);
    write_reg(CFG_FAILSAFE, failsafe);
    cfg_valid <= 1'b0;
  endtask

  // Next timestamp: mostly small steps, sometimes a jump or a random value
  function automatic logic [31:0] pick_ms();
    case ($urandom_range(0, 19))
      0: wall_ms = $urandom();
      1: ;
      2: wall_ms = wall_ms + $urandom_range(1500, 6000);
      default: wall_ms = wall_ms + $urandom_range(0, 900);
    endcase
    return wall_ms;
  endfunction

  // Default registers: walk every phase and the edge cases by hand
  task automatic test_directed_sequence();
    issue_cmd(CMD_QUERY, 32'd0);
    issue_cmd(CMD_REQUEST, 32'd100);
    issue_cmd(CMD_REQUEST, 32'd150);          // already in prequiet
    issue_cmd(CMD_EVALUATE, 32'd200);         // drain done, quiet starts
    issue_cmd(CMD_ACQUIRE, 32'd250);          // refused outside idle
    issue_cmd(CMD_EVALUATE, 32'd1200);        // quiet exactly at minimum
    issue_cmd(CMD_BEGIN_SW, 32'd1210);
    issue_cmd(CMD_BEGIN_RW, 32'd1220);        // not in settle
    issue_cmd(CMD_BEGIN_SETTLE, 32'd1230);
    issue_cmd(CMD_BEGIN_RW, 32'd1729);        // one ms before deadline
    issue_cmd(CMD_BEGIN_RW, 32'd1730);
    issue_cmd(CMD_BEGIN_RW, 32'd1740);        // already waiting
    issue_cmd(CMD_COMPLETE_RW, 32'd1750);
    issue_cmd(CMD_COMPLETE_RW, 32'd1760);
    issue_cmd(CMD_ACQUIRE, 32'd1770);
    issue_cmd(CMD_REQUEST, 32'd1780);
    issue_cmd(CMD_EVALUATE, 32'd1785);        // activity pending
    issue_cmd(CMD_BEGIN_SW, 32'd1790);        // blocked by activity
    issue_cmd(CMD_RELEASE, 32'd1800);
    issue_cmd(CMD_RELEASE, 32'd1810);         // release at zero
    issue_cmd(CMD_QUERY, 32'd3780);           // failsafe boundary
    issue_cmd(CMD_REQUEST, 32'hFFFF_FF00);
    issue_cmd(CMD_EVALUATE, 32'h0000_0100);   // elapsed across wrap
    issue_cmd(CMD_FAIL_CLOSED, 32'h0000_0200);
    issue_cmd(CMD_REQUEST, 32'h0000_0300);    // refused when failed closed
    issue_cmd(CMD_BEGIN_SETTLE, 32'h0000_0400);
    issue_cmd(CMD_FAIL_CLOSED, 32'h0000_0410); // no latch from settle
    issue_cmd(CMD_CANCEL, 32'h0000_0420);
    issue_cmd(CMD_UNUSED_LO, 32'hFFFF_FFFF);
    issue_cmd(CMD_UNUSED_HI, 32'h0000_0000);
    wall_ms = 32'h0000_0420;
    wait_drained();
  endtask

  // Fill the activity count to its limit, try one acquire past it and empty it again, no idling
  task automatic test_count_saturation();
    steady = 1'b1;
    issue_cmd(CMD_CANCEL, pick_ms());
    repeat (ACT_LIMIT + 1) issue_cmd(CMD_ACQUIRE, pick_ms());
    repeat (ACT_LIMIT + 1) issue_cmd(CMD_RELEASE, pick_ms());
    steady = 1'b0;
  endtask

  // One power cycle attempt with random timing, or a single noise item
  task automatic run_session();
    int unsigned n;
    int unsigned k;
    if ($urandom_range(0, 99) < 20) begin
      issue_cmd(4'($urandom_range(0, 15)), pick_ms());
      return;
    end
    if (g_phase != PH_IDLE) issue_cmd(CMD_CANCEL, pick_ms());
    n = $urandom_range(0, 2);
    repeat (n) issue_cmd(CMD_ACQUIRE, pick_ms());
    issue_cmd(CMD_REQUEST, pick_ms());
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1: issue_cmd(CMD_RELEASE, pick_ms());
        2: issue_cmd(CMD_QUERY, pick_ms());
        3: issue_cmd(CMD_ACQUIRE, pick_ms());
        default: issue_cmd(CMD_EVALUATE, pick_ms());
      endcase
    end
    if ($urandom_range(0, 9) == 0) issue_cmd(CMD_FAIL_CLOSED, pick_ms());
    while (g_count != 0 && $urandom_range(0, 3) != 0) issue_cmd(CMD_RELEASE, pick_ms());
    issue_cmd(CMD_EVALUATE, pick_ms());
    issue_cmd(CMD_BEGIN_SW, pick_ms());
    if (g_phase == PH_SWITCHING || $urandom_range(0, 3) == 0)
      issue_cmd(CMD_BEGIN_SETTLE, pick_ms());
    n = $urandom_range(1, 3);
    repeat (n) issue_cmd(CMD_BEGIN_RW, pick_ms());
    issue_cmd(CMD_COMPLETE_RW, pick_ms());
  endtask

  // Random sessions under a sweep of register settings
  task automatic test_random_sessions();
    int unsigned s;
    int unsigned target;
    for (s = 0; s < 6; s++) begin
      case (s)
        0: program_regs(32'd300, 32'd800, 32'd200, 32'd3000);
        1: program_regs(32'd0, 32'd0, 32'd0, 32'd0);
        2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: program_regs(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        4: program_regs(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd1);
        default: program_regs(RST_MIN_QUIET, RST_WAIT_WARN, RST_SETTLE_TIME, RST_FAILSAFE);
      endcase
      steady = (s == 2);
      target = sent_items + RANDOM_ITEMS / 6;
      while (sent_items < target) run_session();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_sequence();
    test_count_saturation();
    test_random_sessions();
    wait_drained();
    if (!mismatch_seen && guard_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
